// ===== hdl/fic_pkg.sv =====
// Shared constants and types for the interval count block.
package fic_pkg;

  localparam int POSITIONS = 65536;
  localparam int IDX_W     = $clog2(POSITIONS);
  localparam int POS_W     = 16;
  localparam int CNT_W     = 32;
  localparam int KW        = ((IDX_W + 1) > (POS_W + 1)) ? (IDX_W + 1) : (POS_W + 1);

  typedef enum logic [2:0] {
    WALK_RD_LEFT,
    WALK_RD_RIGHT,
    WALK_UP_LEFT,
    WALK_UP_LEFT_NEXT,
    WALK_UP_RIGHT,
    WALK_UP_RIGHT_NEXT
  } walk_t;

  typedef struct packed {
    logic  load;
    logic  walk_init;
    logic  step;
    logic  clr;
    logic  out_load;
    walk_t walk;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic walk_end;
    logic clr_last;
  } stat_t;

endpackage

// ===== hdl/fic_ram.sv =====
// Generic single write port RAM with registered read.
module fic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/fic_datapath.sv =====
// Datapath: tree memory, walk index, end counts and result register.
module fic_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  fic_pkg::cmd_t                      cmd,
  output fic_pkg::stat_t                     stat,
  input  logic [2*fic_pkg::POS_W-1:0]        in_data,
  output logic [fic_pkg::CNT_W-1:0]          hit_total,
  output logic                               bad_interval
);

  logic [fic_pkg::POS_W-1:0] left_pos;
  logic [fic_pkg::POS_W-1:0] right_pos;
  logic [fic_pkg::KW-1:0]    k;
  logic [fic_pkg::KW-1:0]    k_low;
  logic [fic_pkg::KW-1:0]    k_start;
  logic [fic_pkg::CNT_W-1:0] ca;
  logic [fic_pkg::CNT_W-1:0] cb;
  logic [fic_pkg::CNT_W-1:0] delta;
  logic [fic_pkg::CNT_W-1:0] delta_start;
  logic [fic_pkg::IDX_W-1:0] clr_cnt;
  logic [fic_pkg::CNT_W-1:0] rdata;
  logic                      is_query;
  logic                      k_out;
  logic                      mem_we;
  logic [fic_pkg::IDX_W-1:0] mem_waddr;
  logic [fic_pkg::CNT_W-1:0] mem_wdata;
  logic [fic_pkg::KW-1:0]    left_ext;
  logic [fic_pkg::KW-1:0]    right_ext;

  assign left_ext  = fic_pkg::KW'(left_pos);
  assign right_ext = fic_pkg::KW'(right_pos);
  assign k_low     = k & (~k + fic_pkg::KW'(1));
  assign k_out     = (k >= fic_pkg::KW'(fic_pkg::POSITIONS));
  assign is_query  = (cmd.walk == fic_pkg::WALK_RD_LEFT) ||
                     (cmd.walk == fic_pkg::WALK_RD_RIGHT);

  always_comb begin
    k_start     = '0;
    delta_start = '0;
    unique case (cmd.walk)
      fic_pkg::WALK_RD_LEFT: begin
        k_start = left_ext;
      end
      fic_pkg::WALK_RD_RIGHT: begin
        k_start = right_ext;
      end
      fic_pkg::WALK_UP_LEFT: begin
        k_start     = left_ext;
        delta_start = ~ca + fic_pkg::CNT_W'(1);
      end
      fic_pkg::WALK_UP_LEFT_NEXT: begin
        k_start     = left_ext + fic_pkg::KW'(1);
        delta_start = ca + fic_pkg::CNT_W'(1);
      end
      fic_pkg::WALK_UP_RIGHT: begin
        k_start     = right_ext;
        delta_start = ~cb;
      end
      fic_pkg::WALK_UP_RIGHT_NEXT: begin
        k_start     = right_ext + fic_pkg::KW'(1);
        delta_start = cb;
      end
      default: begin
        k_start     = '0;
        delta_start = '0;
      end
    endcase
    // A read beyond the tree sees the count of the last slot.
    if (is_query && (k_start >= fic_pkg::KW'(fic_pkg::POSITIONS))) begin
      k_start = fic_pkg::KW'(fic_pkg::POSITIONS - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr) begin
      clr_cnt <= clr_cnt + fic_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left_pos  <= in_data[fic_pkg::POS_W-1:0];
      right_pos <= in_data[2*fic_pkg::POS_W-1:fic_pkg::POS_W];
    end
    if (cmd.walk_init) begin
      k     <= k_start;
      delta <= delta_start;
      if (cmd.walk == fic_pkg::WALK_RD_LEFT) begin
        ca <= '0;
      end
      if (cmd.walk == fic_pkg::WALK_RD_RIGHT) begin
        cb <= '0;
      end
    end else if (cmd.step) begin
      if (is_query) begin
        k <= k - k_low;
        if (cmd.walk == fic_pkg::WALK_RD_LEFT) begin
          ca <= ca + rdata;
        end else begin
          cb <= cb + rdata;
        end
      end else begin
        k <= k + k_low;
      end
    end
    if (cmd.out_load) begin
      bad_interval <= stat.bad;
      hit_total    <= stat.bad ? '0 : ca + cb;
    end
  end

  assign mem_we    = cmd.clr || (cmd.step && !is_query);
  assign mem_waddr = cmd.clr ? clr_cnt : k[fic_pkg::IDX_W-1:0];
  assign mem_wdata = cmd.clr ? '0 : rdata + delta;

  fic_ram #(
    .WIDTH(fic_pkg::CNT_W),
    .DEPTH(fic_pkg::POSITIONS)
  ) u_tree (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(k[fic_pkg::IDX_W-1:0]),
    .rdata(rdata)
  );

  assign stat = '{
    bad:      (left_pos >= right_pos),
    walk_end: (k == '0) || (!is_query && k_out),
    clr_last: (clr_cnt == fic_pkg::IDX_W'(fic_pkg::POSITIONS - 1))
  };

endmodule

// ===== hdl/fic_ctrl.sv =====
// Controller: clearing pass, walk sequencing and stream handshakes.
module fic_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output fic_pkg::cmd_t  cmd,
  input  fic_pkg::stat_t stat
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_INIT,
    ST_RD,
    ST_STEP,
    ST_DONE
  } state_t;

  state_t        state;
  fic_pkg::walk_t walk;
  logic          out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd           = '0;
    cmd.walk      = walk;
    cmd.load      = (state == ST_IDLE) && in_valid;
    cmd.walk_init = (state == ST_INIT);
    cmd.step      = (state == ST_STEP);
    cmd.clr       = (state == ST_CLEAR);
    cmd.out_load  = (state == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      walk      <= fic_pkg::WALK_RD_LEFT;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (stat.clr_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          walk <= fic_pkg::WALK_RD_LEFT;
          if (stat.bad) begin
            state <= ST_DONE;
          end else begin
            state <= ST_INIT;
          end
        end
        ST_INIT: begin
          state <= ST_RD;
        end
        ST_RD: begin
          if (stat.walk_end) begin
            if (walk == fic_pkg::WALK_UP_RIGHT_NEXT) begin
              state <= ST_DONE;
            end else begin
              walk  <= fic_pkg::walk_t'(walk + 3'd1);
              state <= ST_INIT;
            end
          end else begin
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          state <= ST_RD;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/fenwick_interval_count_reset.sv =====
// Top level of the interval count block over a Fenwick difference tree.
// Each transfer names an interval; the block reads the counts at both ends from a Fenwick
// tree of differences held in one single-port-write RAM, resets both ends to zero, adds one
// to every position strictly between them and returns the sum of the two counts. Every tree
// access is a registered read, then a write or accumulate. One item is in work at a time,
// and the next is taken while a finished result waits on the output. After reset the block
// clears all POSITIONS words of the tree, one word a cycle, before it takes its first transfer.
module fenwick_interval_count_reset (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // left_pos [15:0], right_pos [31:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // hit_total [31:0]
  output logic        m_tuser    // bad_interval [0]
);

  fic_pkg::cmd_t  cmd;
  fic_pkg::stat_t stat;

  fic_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  fic_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_data     (s_tdata),
    .hit_total   (m_tdata),
    .bad_interval(m_tuser)
  );

endmodule

// ===== tb/tb_fenwick_interval_count_reset.sv =====
// Testbench for the Fenwick interval count block: directed, random and flow-control tests.
module tb_fenwick_interval_count_reset;

  localparam int TREE_SLOTS  = fic_pkg::POSITIONS;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_WAIT  = 300;

  typedef struct {
    bit [31:0] hit_total;
    bit        bad_interval;
  } interval_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tuser;

  bit [31:0]        shadow_tree [TREE_SLOTS];
  interval_result_t pending_results [$];
  int               error_count;
  int               cycle_count;
  bit               tx_idle_on;
  bit               rx_idle_on;
  int               rx_hold;

  fenwick_interval_count_reset DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic bit [31:0] count_at(int unsigned pos);
    bit [31:0]   acc;
    int unsigned k;
    acc = 32'd0;
    k = (pos >= TREE_SLOTS) ? TREE_SLOTS - 1 : pos;
    while (k != 0) begin
      acc = acc + shadow_tree[k];
      k = k - (k & (~k + 1));
    end
    return acc;
  endfunction

  function automatic void tree_bump(int unsigned pos, bit [31:0] delta);
    int unsigned k;
    k = pos;
    while (k != 0 && k < TREE_SLOTS) begin
      shadow_tree[k] = shadow_tree[k] + delta;
      k = k + (k & (~k + 1));
    end
  endfunction

  function automatic interval_result_t predict_interval(int unsigned left, int unsigned right);
    interval_result_t res;
    bit [31:0]        cnt_left;
    bit [31:0]        cnt_right;
    if (left >= right) begin
      res.hit_total    = 32'd0;
      res.bad_interval = 1'b1;
      return res;
    end
    cnt_left  = count_at(left);
    cnt_right = count_at(right);
    tree_bump(left, -cnt_left);
    tree_bump(left + 1, cnt_left);
    tree_bump(right, -cnt_right);
    tree_bump(right + 1, cnt_right);
    tree_bump(left + 1, 32'd1);
    tree_bump(right, 32'hFFFF_FFFF);
    res.hit_total    = cnt_left + cnt_right;
    res.bad_interval = 1'b0;
    return res;
  endfunction

  task automatic send_interval(input bit [15:0] left, input bit [15:0] right);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {right, left};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_interval(32'(left), 32'(right)));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin : result_check
    interval_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transfer, hit_total %0d bad_interval %0d", $time, m_tdata,
                 m_tuser);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata !== want.hit_total) begin
          $display("%0t: hit_total expected %0d actual %0d", $time, want.hit_total, m_tdata);
          error_count++;
        end
        if (m_tuser !== want.bad_interval) begin
          $display("%0t: bad_interval expected %0d actual %0d", $time, want.bad_interval,
                   m_tuser);
          error_count++;
        end
      end
    end
  end

  initial begin : receiver
    int gap;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = rx_idle_on ? $urandom_range(0, 5) : 0;
      if (rx_hold > 0) begin
        gap = rx_hold;
        rx_hold = 0;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  task automatic pick_window(input int base, output bit [15:0] left, output bit [15:0] right);
    int l;
    l = $urandom_range(base, base + 62);
    left  = 16'(l);
    right = 16'($urandom_range(l + 1, base + 63));
  endtask

  task automatic pick_wide(output bit [15:0] left, output bit [15:0] right);
    int l;
    l = $urandom_range(0, 65534);
    left  = 16'(l);
    right = 16'($urandom_range(l + 1, 65535));
  endtask

  task automatic pick_bad(output bit [15:0] left, output bit [15:0] right);
    int l;
    l = $urandom_range(0, 65535);
    left  = 16'(l);
    right = 16'($urandom_range(0, l));
  endtask

  task automatic pick_mixed(input int base, output bit [15:0] left, output bit [15:0] right);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      pick_bad(left, right);
    end else if (r < 15) begin
      left  = 16'($urandom());
      right = 16'($urandom());
    end else if (r < 75) begin
      pick_window(base, left, right);
    end else begin
      pick_wide(left, right);
    end
  endtask

  function automatic int pick_base();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return 0;
    if (r == 1) return 65535 - 63;
    return $urandom_range(0, 65535 - 63);
  endfunction

  task automatic test_directed_extremes();
    send_interval(16'd0, 16'd1);
    send_interval(16'd0, 16'd65535);
    send_interval(16'd1, 16'd65535);
    send_interval(16'd65534, 16'd65535);
    send_interval(16'd65535, 16'd65535);
    send_interval(16'd65535, 16'd0);
    send_interval(16'd5, 16'd5);
    send_interval(16'd0, 16'd0);
    send_interval(16'd1, 16'd2);
    send_interval(16'd1, 16'd10);
    send_interval(16'd5, 16'd20);
    send_interval(16'd3, 16'd8);
    send_interval(16'd10, 16'd12);
    send_interval(16'd0, 16'd5);
    send_interval(16'd4, 16'd6);
    send_interval(16'd2, 16'd11);
    send_interval(16'd32768, 16'd65535);
    send_interval(16'd32767, 16'd32769);
    send_interval(16'd0, 16'd32768);
    send_interval(16'd65533, 16'd65535);
    send_interval(16'd20, 16'd7);
    send_interval(16'hAAAA, 16'hFFFF);
    send_interval(16'h5555, 16'hAAAA);
  endtask

  task automatic test_random_mix(input int count);
    int        base;
    bit [15:0] left;
    bit [15:0] right;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) base = pick_base();
      if (i % 150 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      pick_mixed(base, left, right);
      send_interval(left, right);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    int        base;
    bit [15:0] left;
    bit [15:0] right;
    base = pick_base();
    tx_idle_on = 1'b0;
    rx_hold = 3000;
    for (int i = 0; i < 60; i++) begin
      pick_window(base, left, right);
      send_interval(left, right);
    end
    tx_idle_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    int        base;
    bit [15:0] left;
    bit [15:0] right;
    base = pick_base();
    for (int i = 0; i < 60; i++) begin
      if (i % 20 == 0) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
        wait_drained();
      end
      pick_mixed(base, left, right);
      send_interval(left, right);
    end
  endtask

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = 32'd0;
    error_count = 0;
    cycle_count = 0;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    rx_hold     = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_extremes();
    test_random_mix(1200);
    test_output_backpressure();
    test_drain_pause();
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
